/* rtl/core/assert_macros.svh */
// Assertion macros shared by the cache RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check with explicit clock and active-low reset.
`define BB_ASSERT_CLK(label, clk_s, rstn_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// Clocked check on the module's clk / rst_n.
`define BB_ASSERT(label, prop, msg) \
  `BB_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

/* rtl/core/bblru_pkg.sv */
// Shared types, codes and defaults for the byte-budget LRU cache.
// No dependencies.
package bblru_pkg;

  localparam int ENTRIES_DEF  = 16;
  localparam int KEY_BITS_DEF = 32;
  localparam logic [39:0] CAP_RESET = 40'd1073741824;

  typedef enum logic [2:0] {
    OP_GET      = 3'd0,
    OP_PUT      = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_CLEAR    = 3'd3,
    OP_CONTAINS = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FIND_WAIT,
    ST_PUT_CHECK,
    ST_EVICT_WAIT,
    ST_PUT_FIND_WAIT,
    ST_PUT_HIT_WR,
    ST_FULL_WAIT,
    ST_INSERT_FREE,
    ST_INSERT_VIC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] key;
    logic [31:0] entry_size;
    logic [31:0] payload_handle;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] payload_out;
    logic        stored;
    logic [4:0]  evicted_count;
    logic [4:0]  entry_count;
    logic [39:0] bytes_used;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic load_item;
    logic scan_start;
    logic scan_old;     // 1: look for the LRU slot, 0: look for the key
    logic recent;       // make found slot most recent
    logic sub_old;      // used -= found slot size
    logic drop;         // invalidate found slot
    logic count_evict;
    logic set_hit;
    logic set_pay;
    logic hit_write;    // rewrite found slot in place
    logic insert;
    logic ins_victim;   // insert into the slot just evicted
    logic clear;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [2:0] opcode;
    logic       scan_done;
    logic       found;
    logic       fits;
    logic       cnt_zero;
    logic       cnt_full;
  } sts_t;

endpackage

/* rtl/core/bblru_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bblru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/bblru_dp.sv */
// Datapath of the byte-budget LRU cache: slot RAM, valid bits, ranks, byte count.
// Depends on bblru_pkg, bblru_ram and assert_macros.svh.
`include "assert_macros.svh"
module bblru_dp import bblru_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [39:0] cfg_wdata,
  input  in_item_t    in_data,
  input  cmd_t        cmd,
  output sts_t        sts,
  output out_item_t   out_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int RW    = KEY_BITS + 64;

  logic [39:0]      cap_r;
  in_item_t         item_r;
  logic [ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0] rank_r [ENTRIES];
  logic [CNT_W-1:0] count_r;
  logic [39:0]      used_r;

  // scan pipeline
  logic [IDX_W-1:0] iss_r;
  logic             iss_act_r;
  logic             rd_v_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic             rd_last_r;
  logic             scan_done_r;
  logic             mode_old_r;

  logic             f_hit_r;
  logic [IDX_W-1:0] f_idx_r;
  logic [31:0]      f_size_r;
  logic [31:0]      f_pay_r;
  logic             free_ok_r;
  logic [IDX_W-1:0] free_idx_r;

  logic [CNT_W-1:0] ev_cnt_r;
  logic             res_hit_r;
  logic [31:0]      res_pay_r;
  logic             res_stored_r;
  out_item_t        out_r;

  logic [KEY_BITS-1:0] key_k;
  logic [RW-1:0]       rdata;
  logic [RW-1:0]       wdata;
  logic                ram_we;
  logic [IDX_W-1:0]    waddr;
  logic [IDX_W-1:0]    ins_slot;
  logic [IDX_W-1:0]    f_rank;
  logic [IDX_W-1:0]    lru_rank;
  logic                rd_match;

  assign key_k    = KEY_BITS'(item_r.key);
  assign f_rank   = rank_r[f_idx_r];
  assign lru_rank = IDX_W'(count_r - CNT_W'(1));
  assign ins_slot = cmd.ins_victim ? f_idx_r : free_idx_r;
  assign ram_we   = cmd.hit_write | cmd.insert;
  assign waddr    = cmd.hit_write ? f_idx_r : ins_slot;
  assign wdata    = {key_k, item_r.entry_size, item_r.payload_handle};

  bblru_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (iss_r),
    .rdata (rdata)
  );

  assign rd_match = valid_r[rd_idx_r] &&
                    (mode_old_r ? (rank_r[rd_idx_r] == lru_rank)
                                : (rdata[RW-1:64] == key_k));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
  end

  // slot scan: one address issued per cycle, read data returned in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r       <= '0;
      iss_act_r   <= 1'b0;
      rd_v_r      <= 1'b0;
      rd_idx_r    <= '0;
      rd_last_r   <= 1'b0;
      scan_done_r <= 1'b0;
      mode_old_r  <= 1'b0;
      f_hit_r     <= 1'b0;
      free_ok_r   <= 1'b0;
    end else if (cmd.scan_start) begin
      iss_r       <= '0;
      iss_act_r   <= 1'b1;
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      scan_done_r <= 1'b0;
      mode_old_r  <= cmd.scan_old;
      f_hit_r     <= 1'b0;
      free_ok_r   <= 1'b0;
    end else begin
      rd_v_r    <= iss_act_r;
      rd_idx_r  <= iss_r;
      rd_last_r <= iss_act_r && (iss_r == IDX_W'(ENTRIES - 1));
      if (iss_act_r) begin
        if (iss_r == IDX_W'(ENTRIES - 1)) begin
          iss_act_r <= 1'b0;
        end else begin
          iss_r <= iss_r + IDX_W'(1);
        end
      end
      if (rd_v_r) begin
        if (rd_match && !f_hit_r) begin
          f_hit_r <= 1'b1;
        end
        if (!mode_old_r && !valid_r[rd_idx_r] && !free_ok_r) begin
          free_ok_r <= 1'b1;
        end
        if (rd_last_r) begin
          scan_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r && !cmd.scan_start) begin
      if (rd_match && !f_hit_r) begin
        f_idx_r  <= rd_idx_r;
        f_size_r <= rdata[63:32];
        f_pay_r  <= rdata[31:0];
      end
      if (!mode_old_r && !valid_r[rd_idx_r] && !free_ok_r) begin
        free_idx_r <= rd_idx_r;
      end
    end
  end

  // slot state and byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
      used_r  <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= '0;
      end
    end else if (cmd.clear) begin
      valid_r <= '0;
      count_r <= '0;
      used_r  <= '0;
      for (int j = 0; j < ENTRIES; j++) begin
        rank_r[j] <= '0;
      end
    end else if (cmd.recent) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (valid_r[j] && (IDX_W'(j) != f_idx_r) && (rank_r[j] < f_rank)) begin
          rank_r[j] <= rank_r[j] + IDX_W'(1);
        end
      end
      rank_r[f_idx_r] <= '0;
      if (cmd.sub_old) begin
        used_r <= used_r - 40'(f_size_r);
      end
    end else if (cmd.drop) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (valid_r[j] && (rank_r[j] > f_rank)) begin
          rank_r[j] <= rank_r[j] - IDX_W'(1);
        end
      end
      rank_r[f_idx_r]  <= '0;
      valid_r[f_idx_r] <= 1'b0;
      count_r          <= count_r - CNT_W'(1);
      used_r           <= used_r - 40'(f_size_r);
    end else if (cmd.hit_write) begin
      used_r <= used_r + 40'(item_r.entry_size);
    end else if (cmd.insert) begin
      for (int j = 0; j < ENTRIES; j++) begin
        if (valid_r[j]) begin
          rank_r[j] <= rank_r[j] + IDX_W'(1);
        end
      end
      rank_r[ins_slot]  <= '0;
      valid_r[ins_slot] <= 1'b1;
      count_r           <= count_r + CNT_W'(1);
      used_r            <= used_r + 40'(item_r.entry_size);
    end
  end

  // per-item result fields
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_cnt_r     <= '0;
      res_hit_r    <= 1'b0;
      res_pay_r    <= '0;
      res_stored_r <= 1'b0;
    end else if (cmd.load_item) begin
      ev_cnt_r     <= '0;
      res_hit_r    <= 1'b0;
      res_pay_r    <= '0;
      res_stored_r <= 1'b0;
    end else begin
      if (cmd.count_evict) begin
        ev_cnt_r <= ev_cnt_r + CNT_W'(1);
      end
      if (cmd.set_hit) begin
        res_hit_r <= 1'b1;
      end
      if (cmd.set_pay) begin
        res_pay_r <= f_pay_r;
      end
      if (cmd.hit_write || cmd.insert) begin
        res_stored_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.hit           <= res_hit_r;
      out_r.payload_out   <= res_pay_r;
      out_r.stored        <= res_stored_r;
      out_r.evicted_count <= (32'(ev_cnt_r) > 31) ? 5'd31 : 5'(ev_cnt_r);
      out_r.entry_count   <= (32'(count_r) > 31) ? 5'd31 : 5'(count_r);
      out_r.bytes_used    <= used_r;
    end
  end

  assign out_data      = out_r;
  assign sts.opcode    = item_r.opcode;
  assign sts.scan_done = scan_done_r;
  assign sts.found     = f_hit_r;
  assign sts.fits      = ({1'b0, used_r} + 41'(item_r.entry_size)) <= {1'b0, cap_r};
  assign sts.cnt_zero  = (count_r == '0);
  assign sts.cnt_full  = (count_r == CNT_W'(ENTRIES));

  `BB_ASSERT(a_count_matches_valid, (32'(count_r) == $countones(valid_r)),
             "entry count out of step with valid bits")
  `BB_ASSERT(a_done_no_pending, (scan_done_r |-> (!rd_v_r && !iss_act_r)),
             "scan done with reads still in flight")
  `BB_ASSERT(a_insert_has_room, (cmd.insert |-> !sts.cnt_full),
             "insert with every slot taken")

endmodule

/* rtl/core/bblru_ctrl.sv */
// Controller state machine of the byte-budget LRU cache; sequences scans and updates.
// Depends on bblru_pkg and assert_macros.svh.
`include "assert_macros.svh"
module bblru_ctrl import bblru_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (sts.opcode)
          OP_GET, OP_REMOVE, OP_CONTAINS: begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_FIND_WAIT;
          end
          OP_PUT: begin
            state_nxt = ST_PUT_CHECK;
          end
          OP_CLEAR: begin
            cmd.clear = 1'b1;
            state_nxt = ST_DONE;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_FIND_WAIT: begin
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
          if (sts.found) begin
            cmd.set_hit = 1'b1;
            case (sts.opcode)
              OP_GET: begin
                cmd.recent  = 1'b1;
                cmd.set_pay = 1'b1;
              end
              OP_REMOVE: begin
                cmd.drop = 1'b1;
              end
              default: begin
              end
            endcase
          end
        end
      end
      ST_PUT_CHECK: begin
        if (!sts.fits && !sts.cnt_zero) begin
          cmd.scan_start = 1'b1;
          cmd.scan_old   = 1'b1;
          state_nxt      = ST_EVICT_WAIT;
        end else if (sts.fits) begin
          cmd.scan_start = 1'b1;
          state_nxt      = ST_PUT_FIND_WAIT;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_EVICT_WAIT: begin
        if (sts.scan_done) begin
          cmd.drop        = sts.found;
          cmd.count_evict = sts.found;
          state_nxt       = ST_PUT_CHECK;
        end
      end
      ST_PUT_FIND_WAIT: begin
        if (sts.scan_done) begin
          if (sts.found) begin
            cmd.recent  = 1'b1;
            cmd.sub_old = 1'b1;
            state_nxt   = ST_PUT_HIT_WR;
          end else if (sts.cnt_full) begin
            cmd.scan_start = 1'b1;
            cmd.scan_old   = 1'b1;
            state_nxt      = ST_FULL_WAIT;
          end else begin
            state_nxt = ST_INSERT_FREE;
          end
        end
      end
      ST_PUT_HIT_WR: begin
        cmd.hit_write = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_FULL_WAIT: begin
        if (sts.scan_done) begin
          cmd.drop        = 1'b1;
          cmd.count_evict = 1'b1;
          state_nxt       = ST_INSERT_VIC;
        end
      end
      ST_INSERT_FREE: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_INSERT_VIC: begin
        cmd.insert     = 1'b1;
        cmd.ins_victim = 1'b1;
        state_nxt      = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  `BB_ASSERT(a_accept_leaves_idle, ((in_valid && !in_stall) |=> (state_r == ST_DISPATCH)),
             "accepted beat did not start processing")
  `BB_ASSERT(a_busy_stalls_input, ((state_r != ST_IDLE) |-> in_stall),
             "input not stalled while busy")
  `BB_ASSERT(a_result_held, ((out_valid_r && out_stall) |=> out_valid_r),
             "stalled result beat dropped")

endmodule

/* rtl/core/byte_budget_lru_cache.sv */
// Byte-budget LRU cache top level: controller plus datapath.
// Depends on bblru_pkg, bblru_ctrl, bblru_dp, bblru_ram.
//
// Fully associative cache of ENTRIES slots (key, byte size, payload handle) kept
// in LRU order, with a total byte budget set through cfg_wdata (40 bits, reset 1 GiB).
// One input beat is taken at a time and yields exactly one result beat. Each key
// lookup or LRU search walks the slot RAM one slot per cycle through its single
// read port. A put first evicts LRU entries until its size fits the budget, then
// searches for its key; a new key into a full cache adds one more LRU pass to
// evict a victim. Clear and unknown opcodes make no pass. A new beat is accepted
// once the previous one has reached the output register, even if that result is
// still stalled. Slot contents have no reset; valid bits and ranks clear at reset,
// so no clearing pass is needed.
// Lowering the budget takes effect at the next put, which evicts as needed.
module byte_budget_lru_cache import bblru_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [39:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // sequencing: one state per scan / update step
  bblru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // slot storage, recency ranks, byte accounting, result register
  bblru_dp #(.ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

/* test/testbench.sv */
// Self-checking testbench for byte_budget_lru_cache: directed and random beats.
// Depends on bblru_pkg and the cache RTL; holds its own cache predictor.
`timescale 1ns / 100ps

module testbench;
  import bblru_pkg::*;

  localparam int SLOTS = 16;
  localparam int LIMIT = 20000;   // idle cycles before the watchdog trips

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_we;
  logic [39:0] cfg_wdata;

  byte_budget_lru_cache uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Shadow cache state
  logic [31:0] sh_key  [SLOTS];
  logic [31:0] sh_size [SLOTS];
  logic [31:0] sh_pay  [SLOTS];
  logic        sh_vld  [SLOTS];
  int unsigned sh_rank [SLOTS];
  logic [39:0] sh_used;
  logic [39:0] sh_budget;

  out_item_t   pending_results[$];
  int          fail_count;
  int          beats_sent;
  int          beats_checked;
  int          idle_cycles;
  int          send_idle_pct;
  int          stall_pct;

  // Keys are drawn mostly from a small pool so hits and replacements happen
  logic [31:0] key_pool[8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int shadow_find(logic [31:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (sh_vld[i] && sh_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int shadow_count();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) if (sh_vld[i]) n++;
    return n;
  endfunction

  function automatic void shadow_touch(int s);
    int unsigned r;
    r = sh_rank[s];
    for (int j = 0; j < SLOTS; j++)
      if (sh_vld[j] && j != s && sh_rank[j] < r) sh_rank[j]++;
    sh_rank[s] = 0;
  endfunction

  function automatic void shadow_drop(int s);
    int unsigned r;
    r = sh_rank[s];
    sh_vld[s] = 1'b0;
    sh_used = sh_used - 40'(sh_size[s]);
    for (int j = 0; j < SLOTS; j++)
      if (sh_vld[j] && sh_rank[j] > r) sh_rank[j]--;
    sh_rank[s] = 0;
  endfunction

  function automatic void shadow_evict_lru();
    int b;
    b = -1;
    for (int i = 0; i < SLOTS; i++)
      if (sh_vld[i] && (b < 0 || sh_rank[i] > sh_rank[b])) b = i;
    if (b >= 0) shadow_drop(b);
  endfunction

  // Apply one operation to the shadow cache and return the expected result
  function automatic out_item_t cache_outcome(in_item_t it);
    out_item_t r;
    int s;
    int ev;
    r = '0;
    ev = 0;
    case (it.opcode)
      OP_GET: begin
        s = shadow_find(it.key);
        if (s >= 0) begin
          r.hit = 1'b1;
          r.payload_out = sh_pay[s];
          shadow_touch(s);
        end
      end
      OP_PUT: begin
        // 41-bit sums: used plus size may pass 40 bits
        while ({1'b0, sh_used} + 41'(it.entry_size) > {1'b0, sh_budget} &&
               shadow_count() > 0) begin
          shadow_evict_lru();
          ev++;
        end
        if ({1'b0, sh_used} + 41'(it.entry_size) <= {1'b0, sh_budget}) begin
          s = shadow_find(it.key);
          if (s >= 0) begin
            sh_used = sh_used - 40'(sh_size[s]);
            shadow_touch(s);
          end else begin
            if (shadow_count() >= SLOTS) begin
              shadow_evict_lru();
              ev++;
            end
            s = 0;
            while (s < SLOTS && sh_vld[s]) s++;
            for (int i = 0; i < SLOTS; i++) if (sh_vld[i]) sh_rank[i]++;
            sh_vld[s] = 1'b1;
            sh_rank[s] = 0;
            sh_key[s] = it.key;
          end
          sh_size[s] = it.entry_size;
          sh_pay[s] = it.payload_handle;
          sh_used = sh_used + 40'(it.entry_size);
          r.stored = 1'b1;
        end
        r.evicted_count = 5'(ev);
      end
      OP_REMOVE: begin
        s = shadow_find(it.key);
        if (s >= 0) begin
          r.hit = 1'b1;
          shadow_drop(s);
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          sh_vld[i] = 1'b0;
          sh_rank[i] = 0;
        end
        sh_used = '0;
      end
      OP_CONTAINS: begin
        if (shadow_find(it.key) >= 0) r.hit = 1'b1;
      end
      default: ;
    endcase
    r.entry_count = 5'(shadow_count());
    r.bytes_used = sh_used;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH beat %0d %s: got %0h want %0h", beats_checked, what, got, want);
    fail_count++;
  endtask

  // Result checker and stall driver
  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected beat", 64'(out_data), 64'd0);
      end else begin
        w = pending_results.pop_front();
        if (out_data.hit !== w.hit)
          report_mismatch("hit", 64'(out_data.hit), 64'(w.hit));
        if (out_data.payload_out !== w.payload_out)
          report_mismatch("payload_out", 64'(out_data.payload_out), 64'(w.payload_out));
        if (out_data.stored !== w.stored)
          report_mismatch("stored", 64'(out_data.stored), 64'(w.stored));
        if (out_data.evicted_count !== w.evicted_count)
          report_mismatch("evicted_count", 64'(out_data.evicted_count),
                          64'(w.evicted_count));
        if (out_data.entry_count !== w.entry_count)
          report_mismatch("entry_count", 64'(out_data.entry_count), 64'(w.entry_count));
        if (out_data.bytes_used !== w.bytes_used)
          report_mismatch("bytes_used", 64'(out_data.bytes_used), 64'(w.bytes_used));
      end
      beats_checked++;
    end
  end

  always @(negedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  // Watchdog: cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("watchdog: no progress for %0d cycles", LIMIT);
      $display("byte_budget_lru_cache verification failed");
      $finish;
    end
  end

  // Send one beat; the prediction is taken at the accepting edge
  task automatic send_beat(in_item_t it);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk);
    in_data = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results = {pending_results, cache_outcome(it)};
    beats_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_budget(logic [39:0] v);
    drain();
    cfg_wdata <= v;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
    sh_budget = v;
  endtask

  function automatic in_item_t make_beat(op_t op, logic [31:0] k, logic [31:0] sz,
                                         logic [31:0] p);
    in_item_t it;
    it.opcode = op;
    it.key = k;
    it.entry_size = sz;
    it.payload_handle = p;
    return it;
  endfunction

  function automatic in_item_t random_beat();
    in_item_t it;
    int pick;
    it.key = ($urandom_range(9) < 8) ? key_pool[$urandom_range(7)] : $urandom;
    it.payload_handle = $urandom;
    pick = $urandom_range(99);
    it.entry_size = (pick < 70) ? 32'($urandom_range(300)) :
                    (pick < 90) ? 32'($urandom_range(2000)) : $urandom;
    pick = $urandom_range(99);
    it.opcode = (pick < 40) ? OP_PUT : (pick < 65) ? OP_GET : (pick < 80) ? OP_CONTAINS :
                (pick < 93) ? OP_REMOVE : (pick < 96) ? OP_CLEAR : 3'($urandom_range(5, 7));
    return it;
  endfunction

  task automatic test_directed_ops();
    send_beat(make_beat(OP_GET, 32'h0, 32'd0, 32'd0));
    send_beat(make_beat(OP_PUT, 32'hFFFF_FFFF, 32'd100, 32'hFFFF_FFFF));
    send_beat(make_beat(OP_PUT, 32'h0, 32'd0, 32'h0));
    send_beat(make_beat(OP_GET, 32'hFFFF_FFFF, 32'd0, 32'd0));
    send_beat(make_beat(OP_CONTAINS, 32'h0, 32'd0, 32'd0));
    send_beat(make_beat(OP_PUT, 32'hFFFF_FFFF, 32'd500, 32'hA5A5_5A5A)); // replace in place
    send_beat(make_beat(OP_REMOVE, 32'hFFFF_FFFF, 32'd0, 32'd0));
    send_beat(make_beat(OP_REMOVE, 32'h1234, 32'd0, 32'd0));
    send_beat(make_beat(op_t'(3'd7), 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF)); // unknown op
    send_beat(make_beat(op_t'(3'd5), 32'h1, 32'h1, 32'h1));
    send_beat(make_beat(OP_PUT, 32'h55, 32'hFFFF_FFFF, 32'h1)); // too big for 1 GiB
    send_beat(make_beat(OP_CLEAR, 32'h0, 32'd0, 32'd0));
  endtask

  task automatic test_full_set();
    // Fill all slots, then two more new keys each force an LRU eviction
    for (int i = 0; i < SLOTS + 2; i++)
      send_beat(make_beat(OP_PUT, 32'(i + 16), 32'd10, 32'(i)));
    send_beat(make_beat(OP_GET, 32'd18, 32'd0, 32'd0));
    send_beat(make_beat(OP_CONTAINS, 32'd16, 32'd0, 32'd0));
  endtask

  task automatic test_budget_squeeze();
    // Tight budget: existing key evicted by its own put, then an oversize drop
    set_budget(40'd100);
    send_beat(make_beat(OP_CLEAR, 32'd0, 32'd0, 32'd0));
    send_beat(make_beat(OP_PUT, 32'd1, 32'd60, 32'd11));
    send_beat(make_beat(OP_PUT, 32'd2, 32'd30, 32'd22));
    send_beat(make_beat(OP_PUT, 32'd1, 32'd80, 32'd33));
    send_beat(make_beat(OP_PUT, 32'd3, 32'd101, 32'd44));
    set_budget(40'd0);
    send_beat(make_beat(OP_PUT, 32'd4, 32'd0, 32'd55));
    send_beat(make_beat(OP_PUT, 32'd5, 32'd1, 32'd66));
    set_budget(40'hFF_FFFF_FFFF);
    send_beat(make_beat(OP_PUT, 32'd6, 32'hFFFF_FFFF, 32'd77));
    send_beat(make_beat(OP_PUT, 32'd7, 32'hFFFF_FFFF, 32'd88));
  endtask

  task automatic test_random_phase(int n, int idle_pct, int stall_p, logic [39:0] budget);
    set_budget(budget);
    send_idle_pct = idle_pct;
    stall_pct = stall_p;
    for (int i = 0; i < n; i++) send_beat(random_beat());
  endtask

  task automatic test_quiet_pause();
    // Sender holds off until every result is back, then resumes
    for (int i = 0; i < 10; i++) send_beat(random_beat());
    while (pending_results.size() != 0) @(negedge clk);
    for (int i = 0; i < 10; i++) send_beat(random_beat());
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    fail_count = 0;
    beats_sent = 0;
    beats_checked = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    sh_used = '0;
    sh_budget = CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      sh_vld[i] = 1'b0;
      sh_rank[i] = 0;
      sh_key[i] = '0;
      sh_size[i] = '0;
      sh_pay[i] = '0;
    end
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_ops();
    test_full_set();
    test_budget_squeeze();
    test_random_phase(300, 0, 0, 40'd1000);
    test_random_phase(250, 79, 0, 40'd3000);
    test_random_phase(250, 0, 79, 40'd600);
    test_random_phase(250, 24, 24, CAP_RESET);
    test_quiet_pause();
    test_random_phase(150, 0, 0, 40'd200);
    drain();
    repeat (100) @(negedge clk);

    $display("Ran %0d beats (%0d results checked) over budgets 0 to max,", beats_sent,
             beats_checked);
    $display("covering all ops, evictions, oversize drops and random idle/stall phases.");
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("byte_budget_lru_cache verification clean");
    end else begin
      $display("byte_budget_lru_cache verification failed");
    end
    $finish;
  end

endmodule

/* byte_budget_lru_cache.f */
+incdir+rtl/core
rtl/core/bblru_pkg.sv
rtl/core/bblru_ram.sv
rtl/core/bblru_dp.sv
rtl/core/bblru_ctrl.sv
rtl/core/byte_budget_lru_cache.sv
test/testbench.sv
